>>> hdl/ihwl_pkg.sv
// Shared types, codes and the hex digit helper function of the hex word loader.
package ihwl_pkg;

    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;

    localparam logic [7:0] REC_DATA    = 8'h00;
    localparam logic [7:0] REC_EOF     = 8'h01;
    localparam logic [7:0] REC_EXT_LIN = 8'h04;

    typedef enum logic [2:0] {
        KIND_WRITE     = 3'd0,
        KIND_OK        = 3'd1,
        KIND_DONE      = 3'd2,
        KIND_CSUM_ERR  = 3'd3,
        KIND_INVALID   = 3'd4,
        KIND_BAD_DIGIT = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] word_address;
        logic [15:0] word_data;
        logic        odd_byte;
    } result_t;

    // Returns the digit value in the low four bits, or bit 4 set for a non-hex character.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] val;
        if (c inside {[8'h30:8'h39]}) begin
            val = {1'b0, c[3:0]};
        end else if (c inside {[8'h61:8'h66]}) begin
            val = {1'b0, 4'(c - 8'h57)};
        end else if (c inside {[8'h41:8'h46]}) begin
            val = {1'b0, 4'(c - 8'h37)};
        end else begin
            val = 5'h10;
        end
        return val;
    endfunction

endpackage

>>> hdl/ihwl_parser.sv
// Record parser: parse state registers and the per-character update logic.
module ihwl_parser import ihwl_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic       command,
    input  logic [7:0] character,
    input  logic       source_mode,
    output logic       res_valid,
    output result_t    res
);

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_ADDR = 3'd2,
        PH_TYPE = 3'd3,
        PH_DATA = 3'd4,
        PH_CSUM = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  nib_reg, nib_next;
    logic [15:0] acc_reg, acc_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  rtype_reg, rtype_next;
    logic [31:0] addr_reg, addr_next;
    logic [7:0]  sum_reg, sum_next;
    logic        finished_reg, finished_next;

    logic [4:0]  digit;
    logic        wide;
    logic        need4;
    logic        field_done;
    logic [15:0] acc_new;

    always_comb begin
        phase_next    = phase_reg;
        nib_next      = nib_reg;
        acc_next      = acc_reg;
        left_next     = left_reg;
        rtype_next    = rtype_reg;
        addr_next     = addr_reg;
        sum_next      = sum_reg;
        finished_next = finished_reg;
        res_valid     = 1'b0;
        res           = '0;
        res.kind      = KIND_WRITE;

        digit      = hex_value(character);
        wide       = (phase_reg == PH_DATA) && (rtype_reg == REC_DATA ||
                     rtype_reg == REC_EXT_LIN) && (left_reg >= 8'd2);
        need4      = (phase_reg == PH_ADDR) || wide;
        field_done = need4 ? (nib_reg == 2'd3) : (nib_reg != 2'd0);
        acc_new    = {acc_reg[11:0], digit[3:0]};

        if (in_valid) begin
            if (command) begin
                phase_next    = PH_HUNT;
                nib_next      = '0;
                acc_next      = '0;
                left_next     = '0;
                rtype_next    = '0;
                addr_next     = '0;
                sum_next      = '0;
                finished_next = 1'b0;
            end else if (!finished_reg) begin
                if (phase_reg == PH_HUNT) begin
                    if (character == CHAR_COLON) begin
                        phase_next = PH_LEN;
                        nib_next   = '0;
                        acc_next   = '0;
                        sum_next   = '0;
                    end else if (source_mode && character == CHAR_UPPER_F) begin
                        finished_next = 1'b1;
                        res_valid     = 1'b1;
                        res.kind      = KIND_INVALID;
                    end
                end else if (digit[4]) begin
                    phase_next = PH_HUNT;
                    nib_next   = '0;
                    acc_next   = '0;
                    res_valid  = 1'b1;
                    res.kind   = KIND_BAD_DIGIT;
                end else if (!field_done) begin
                    nib_next = nib_reg + 2'd1;
                    acc_next = acc_new;
                end else begin
                    nib_next = '0;
                    acc_next = '0;
                    case (phase_reg)
                        PH_LEN: begin
                            left_next  = acc_new[7:0];
                            sum_next   = sum_reg + acc_new[7:0];
                            phase_next = PH_ADDR;
                        end
                        PH_ADDR: begin
                            addr_next  = {addr_reg[31:16], acc_new};
                            sum_next   = sum_reg + acc_new[15:8] + acc_new[7:0];
                            phase_next = PH_TYPE;
                        end
                        PH_TYPE: begin
                            rtype_next = acc_new[7:0];
                            sum_next   = sum_reg + acc_new[7:0];
                            phase_next = (left_reg != 8'd0) ? PH_DATA : PH_CSUM;
                        end
                        PH_DATA: begin
                            if (wide) begin
                                sum_next  = sum_reg + acc_new[15:8] + acc_new[7:0];
                                left_next = left_reg - 8'd2;
                                if (rtype_reg == REC_DATA) begin
                                    res_valid        = 1'b1;
                                    res.kind         = KIND_WRITE;
                                    res.word_address = addr_reg;
                                    res.word_data    = acc_new;
                                    addr_next        = addr_reg + 32'd1;
                                end else begin
                                    addr_next = {acc_new, addr_reg[15:0]};
                                end
                            end else begin
                                sum_next  = sum_reg + acc_new[7:0];
                                left_next = left_reg - 8'd1;
                                if (rtype_reg == REC_DATA) begin
                                    res_valid        = 1'b1;
                                    res.kind         = KIND_WRITE;
                                    res.word_address = addr_reg;
                                    res.word_data    = {8'h00, acc_new[7:0]};
                                    res.odd_byte     = 1'b1;
                                    addr_next        = addr_reg + 32'd1;
                                end
                            end
                            if (left_next == 8'd0) begin
                                phase_next = PH_CSUM;
                            end
                        end
                        PH_CSUM: begin
                            res_valid = 1'b1;
                            if (acc_new[7:0] != (8'd0 - sum_reg)) begin
                                finished_next = 1'b1;
                                res.kind      = KIND_CSUM_ERR;
                            end else if (rtype_reg == REC_EOF) begin
                                finished_next = 1'b1;
                                res.kind      = KIND_DONE;
                            end else begin
                                phase_next = PH_HUNT;
                                res.kind   = KIND_OK;
                            end
                        end
                        default: begin
                            phase_next = PH_HUNT;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT;
            nib_reg      <= '0;
            acc_reg      <= '0;
            left_reg     <= '0;
            rtype_reg    <= '0;
            addr_reg     <= '0;
            sum_reg      <= '0;
            finished_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            nib_reg      <= nib_next;
            acc_reg      <= acc_next;
            left_reg     <= left_next;
            rtype_reg    <= rtype_next;
            addr_reg     <= addr_next;
            sum_reg      <= sum_next;
            finished_reg <= finished_next;
        end
    end

`ifndef SYNTHESIS
    a_res_needs_request: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (in_valid && !command))
        else $error("parser result without an accepted character");

    a_terminal_sets_finished: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && (res.kind == KIND_DONE || res.kind == KIND_CSUM_ERR ||
         res.kind == KIND_INVALID)) |=> finished_reg)
        else $error("terminal result did not stop the load");

    a_status_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.kind != KIND_WRITE) |->
        (res.word_address == 32'd0 && res.word_data == 16'd0 && !res.odd_byte))
        else $error("status result carries a nonzero payload");

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && command) |=> (phase_reg == PH_HUNT && !finished_reg &&
         addr_reg == 32'd0))
        else $error("restart did not clear the parse state");

    a_finished_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        finished_reg |-> !res_valid)
        else $error("result produced after the load finished");
`endif

endmodule

>>> hdl/ihwl_out_reg.sv
// Result register that holds one result item until the downstream side takes it.
module ihwl_out_reg import ihwl_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t load_data,
    output logic    free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    valid_reg;
    result_t data_reg;

    // A new result may be loaded when the register is empty or drains this cycle.
    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (free && load) begin
            data_reg <= load_data;
        end
    end

endmodule

>>> hdl/intel_hex_word_loader_unit.sv
// Top level of the Intel HEX word loader: stream ports, mode register and result register.
//
// The loader takes Intel HEX text one character per request on the s_ stream
// and sends word writes and status events on the m_ stream. Each character is
// accepted on a handshake and updates the parse state directly; any result
// it causes lands in a one-entry result register and appears on the m_ side
// the next cycle. Input is taken every cycle, one character per clock, for as
// long as the result register is empty or being drained in the same cycle, so
// the sustained rate is one character per cycle and only downstream stalls
// slow it. A restart request (s_tuser set) clears all parse state, including
// the load address and the finished flag, without producing a result. After a
// checksum error, an invalid image or the end-of-file record, characters are
// dropped silently until a restart. Word writes are issued as data arrives,
// before the record checksum is known, so a consumer should treat the load as
// good only after a load-done event. The source mode register is written on
// its own channel, which is always ready; write it only while the loader is
// idle. Mode 1 (stored image) fails the load on an 'F' seen between records.
module intel_hex_word_loader_unit import ihwl_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write channel: the source mode bit.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,

    // Character stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tuser,   // [0] command: 0 character, 1 restart

    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [31:0] word_address, [47:32] word_data,
                                   // [48] odd_byte, [55:49] zero
    output logic [2:0]  m_tuser    // [2:0] kind
);

    logic    source_mode_reg;
    logic    s_accept;
    logic    res_valid;
    result_t res;
    logic    out_free;
    result_t out_data;

    // The mode register never stalls a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            source_mode_reg <= cfg_data;
        end
    end

    // Every character may cause a result, so a character is taken only when
    // the result register can hold one.
    assign s_tready = out_free;
    assign s_accept = s_tvalid && s_tready;

    ihwl_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_accept),
        .command     (s_tuser),
        .character   (s_tdata),
        .source_mode (source_mode_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    ihwl_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_valid),
        .load_data (res),
        .free      (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {7'd0, out_data.odd_byte, out_data.word_data, out_data.word_address};
    assign m_tuser = out_data.kind;

endmodule
